FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL. Both sample on clk and are off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// A condition that must hold at the clock edge after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/tlp_pkg.sv
package tlp_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_RUN   = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  localparam int IN_W  = 96;
  localparam int OUT_W = 56;

  localparam logic [0:0] CFG_ALPHA = 1'b0;
  localparam logic [0:0] CFG_GYRO  = 1'b1;

  localparam logic [16:0] ALPHA_RESET = 17'd64225;
  localparam logic [23:0] GYRO_RESET  = 24'd256141;
  localparam logic [16:0] ALPHA_ONE   = 17'd65536;

  localparam int DIV_W = 54;
  // ceil(2^61 / 125); exact quotient by 125 for any dividend below 2^54.
  localparam logic [54:0] DIV_RECIP = 55'd18446744073709552;

  typedef struct packed {
    logic [31:0]        mag2;   // accel_x^2 + accel_z^2
    logic signed [15:0] ay;
    logic               zero;   // all three accelerometer axes are zero
    logic               neg;    // gyro rate is negative
    logic [39:0]        gmag;   // |gyro rate| * gyro_gain
    logic [31:0]        dt;     // elapsed ms, never zero
  } entry_t;

  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/tilt_complementary_filter.sv
// Tilt complementary filter.
// Input stream (s_t*): one word per IMU sample carrying the raw accelerometer
// triple, the raw X gyro rate and a millisecond timestamp. Output stream (m_t*):
// one word per input word with the filtered angle as signed Q10.16 degrees and
// the accelerometer angle as signed Q7.16 degrees.
// The front stage takes a word while the queue has room, forms dt, the squared
// horizontal magnitude and the scaled gyro magnitude, and places them in a
// two-entry queue. The back stage runs a 16-step square root followed by the
// CORDIC steps, in parallel with the gyro multiply and a divide by 256000 done
// as a shift and a reciprocal multiply, then blends. The CORDIC steps are
// skipped when all accelerometer axes are zero; the accelerometer path is the
// longer one and decides when the blend starts. The back stage takes one word
// at a time and pops the next only after loading the last result for output.
// While the receiver stalls, the result is held in the output register and the
// back stage finishes the next word up to the blend write; the front keeps
// accepting until the queue is full.
// Reset clears the stored angle and stored time to zero and loads the default
// gains (alpha 0.98, gyro 1/65.5). Write the gains through cfg_* only while
// no word is in flight.
module tilt_complementary_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // accel_x[15:0], accel_y[31:16], accel_z[47:32], gyro_x_rate[63:48],
  // timestamp_ms[95:64]
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // filtered_angle[26:0], accel_angle[50:27], zero pad[55:51]
  output logic [55:0] m_tdata,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);
  import tlp_pkg::*;
  `include "assert_macros.svh"

  logic [16:0] alpha_gain;
  logic [23:0] gyro_gain;
  logic        q_push, q_full, q_pop, q_valid;
  entry_t      q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain <= ALPHA_RESET;
      gyro_gain  <= GYRO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALPHA: alpha_gain <= cfg_wdata[16:0];
        CFG_GYRO:  gyro_gain  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tlp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .gyro_gain (gyro_gain),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  tlp_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  tlp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .alpha_gain (alpha_gain),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  `ASSERT_ALWAYS(a_no_overflow, !(q_push && q_full))
  `ASSERT_ALWAYS(a_pop_has_data, !q_pop || q_valid)
  `ASSERT_NEXT(a_push_fills, q_push && !q_pop, q_valid)

endmodule

FILE: src/tlp_front.sv
module tlp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // accel_x, accel_y, accel_z, gyro_x_rate, timestamp_ms
  input  logic [95:0]           s_tdata,
  input  logic [23:0]           gyro_gain,
  input  logic                  q_full,
  output logic                  q_push,
  output tlp_pkg::entry_t       q_wdata
);
  import tlp_pkg::*;

  logic [31:0]        last_time;
  logic signed [15:0] ax, ay, az, rate;
  logic [31:0]        ts, diff;
  logic signed [31:0] sqx, sqz;
  logic [15:0]        rmag;

  assign ax   = s_tdata[15:0];
  assign ay   = s_tdata[31:16];
  assign az   = s_tdata[47:32];
  assign rate = s_tdata[63:48];
  assign ts   = s_tdata[95:64];

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    sqx  = ax * ax;
    sqz  = az * az;
    rmag = rate[15] ? 16'(-rate) : 16'(rate);
    diff = ts - last_time;
    q_wdata.mag2 = 32'(sqx) + 32'(sqz);
    q_wdata.ay   = ay;
    q_wdata.zero = (ax == 16'sd0) && (ay == 16'sd0) && (az == 16'sd0);
    q_wdata.neg  = rate[15];
    q_wdata.gmag = 40'(rmag) * 40'(gyro_gain);
    q_wdata.dt   = (diff == 32'd0) ? 32'd1 : diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= 32'd0;
    end else if (q_push) begin
      last_time <= ts;
    end
  end

endmodule

FILE: src/tlp_fifo.sv
module tlp_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tlp_pkg::entry_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output tlp_pkg::entry_t rdata
);
  import tlp_pkg::*;

  entry_t     mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: src/tlp_back.sv
module tlp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic [16:0]     alpha_gain,
  input  logic            q_valid,
  input  tlp_pkg::entry_t q_rdata,
  output logic            q_pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  // filtered_angle[26:0], accel_angle[50:27], zero pad
  output logic [55:0]     m_tdata
);
  import tlp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_BLEND = 4'b0100,
    ST_FIN   = 4'b1000
  } main_state_t;

  typedef enum logic [3:0] {
    A_SQ   = 4'b0001,
    A_LOAD = 4'b0010,
    A_CO   = 4'b0100,
    A_DONE = 4'b1000
  } acc_state_t;

  typedef enum logic [4:0] {
    G_MUL0 = 5'b00001,
    G_MUL1 = 5'b00010,
    G_CAP  = 5'b00100,
    G_DIV  = 5'b01000,
    G_DONE = 5'b10000
  } gyro_state_t;

  localparam logic [60:0] DIV_CAP = 61'd125 << 46;

  main_state_t state;
  acc_state_t  a_st;
  gyro_state_t g_st;

  logic signed [26:0] angle_store;
  logic [26:0]        out_filt;
  logic [23:0]        out_acc;

  // Square root and CORDIC registers.
  logic [31:0]        sq_n, sq_res, sq_bit;
  logic [3:0]         sq_cnt;
  logic signed [15:0] a_ay;
  logic               a_zero;
  logic signed [33:0] cx, cy;
  logic signed [24:0] cz;
  logic [4:0]         ccnt;

  // Gyro increment registers.
  logic [39:0] g_mag;
  logic [31:0] g_dt;
  logic        g_neg;
  logic [71:0] g_prod;
  logic [DIV_W-1:0] g_d;
  logic [106:0] g_acc;
  logic [1:0]  g_cnt;

  // Blend registers.
  logic [1:0]         bcnt;
  logic signed [45:0] sum_r;
  logic signed [23:0] acc_r;
  logic [16:0]        alpha_c;
  logic signed [63:0] pacc;

  // Combinational step values.
  logic [32:0]        sq_t;
  logic signed [33:0] dx, dy;
  logic signed [24:0] ang;
  logic [26:0]        pm_a;
  logic [27:0]        pm_b;
  logic [5:0]         pm_sh;
  logic [54:0]        pm_p;
  logic [106:0]       pm_s;
  logic [60:0]        g_shift;
  logic signed [47:0] inc48, sum48;
  logic [16:0]        beta;
  logic [39:0]        p_lo;
  logic signed [40:0] p_hi;
  logic signed [41:0] p_beta;
  logic signed [63:0] tot, sh;
  logic [26:0]        filt;

  always_comb begin
    sq_t = {1'b0, sq_res} + {1'b0, sq_bit};
    dx   = cy >>> ccnt;
    dy   = cx >>> ccnt;
    ang  = 25'($signed({1'b0, atan_q16(ccnt)}));

    // The quotient by 125 is the product with the reciprocal, taken one
    // partial product per cycle.
    case (g_cnt)
      2'd0: begin
        pm_a  = g_d[26:0];
        pm_b  = DIV_RECIP[27:0];
        pm_sh = 6'd0;
      end
      2'd1: begin
        pm_a  = g_d[26:0];
        pm_b  = {1'b0, DIV_RECIP[54:28]};
        pm_sh = 6'd28;
      end
      2'd2: begin
        pm_a  = g_d[53:27];
        pm_b  = DIV_RECIP[27:0];
        pm_sh = 6'd27;
      end
      default: begin
        pm_a  = g_d[53:27];
        pm_b  = {1'b0, DIV_RECIP[54:28]};
        pm_sh = 6'd55;
      end
    endcase
    pm_p = 55'(pm_a) * 55'(pm_b);
    pm_s = 107'(pm_p) << pm_sh;

    g_shift = g_prod[71:11];

    inc48 = g_neg ? -$signed({2'b00, g_acc[106:61]}) : $signed({2'b00, g_acc[106:61]});
    sum48 = 48'(angle_store) + inc48;

    beta   = ALPHA_ONE - alpha_c;
    p_lo   = 40'(alpha_c) * 40'(sum_r[22:0]);
    p_hi   = $signed({1'b0, alpha_c}) * $signed(sum_r[45:23]);
    p_beta = $signed({1'b0, beta}) * acc_r;

    tot = pacc + 64'sd32768;
    sh  = tot >>> 16;
    if (sh > 64'sd67108863) begin
      filt = 27'h3FFFFFF;
    end else if (sh < -64'sd67108864) begin
      filt = 27'h4000000;
    end else begin
      filt = sh[26:0];
    end
  end

  assign q_pop   = (state == ST_IDLE) && q_valid;
  assign m_tdata = {5'd0, out_acc, out_filt};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      a_st        <= A_DONE;
      g_st        <= G_DONE;
      m_tvalid    <= 1'b0;
      angle_store <= 27'sd0;
    end else begin
      if (m_tvalid && m_tready && state != ST_FIN) m_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            sq_n   <= q_rdata.mag2;
            sq_res <= 32'd0;
            sq_bit <= 32'd1 << 30;
            sq_cnt <= 4'd0;
            a_ay   <= q_rdata.ay;
            a_zero <= q_rdata.zero;
            g_mag  <= q_rdata.gmag;
            g_dt   <= q_rdata.dt;
            g_neg  <= q_rdata.neg;
            a_st   <= A_SQ;
            g_st   <= G_MUL0;
            state  <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (a_st == A_DONE && g_st == G_DONE) begin
            bcnt  <= 2'd0;
            state <= ST_BLEND;
          end
        end
        ST_BLEND: begin
          bcnt <= bcnt + 2'd1;
          case (bcnt)
            2'd0: begin
              if (sum48 > 48'sh100000000000) begin
                sum_r <= 46'sh100000000000;
              end else if (sum48 < -48'sh100000000000) begin
                sum_r <= -46'sh100000000000;
              end else begin
                sum_r <= sum48[45:0];
              end
              if (cz > 25'sd5898240) begin
                acc_r <= 24'sd5898240;
              end else if (cz < -25'sd5898240) begin
                acc_r <= -24'sd5898240;
              end else begin
                acc_r <= cz[23:0];
              end
              alpha_c <= (alpha_gain > ALPHA_ONE) ? ALPHA_ONE : alpha_gain;
            end
            2'd1: pacc <= $signed({24'd0, p_lo});
            2'd2: pacc <= pacc + (64'(p_hi) <<< 23);
            default: begin
              pacc  <= pacc + 64'(p_beta);
              state <= ST_FIN;
            end
          endcase
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            out_filt    <= filt;
            out_acc     <= acc_r;
            m_tvalid    <= 1'b1;
            angle_store <= filt;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      unique case (a_st)
        A_SQ: begin
          if ({1'b0, sq_n} >= sq_t) begin
            sq_n   <= sq_n - sq_t[31:0];
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt + 4'd1;
          if (sq_cnt == 4'd15) a_st <= A_LOAD;
        end
        A_LOAD: begin
          cx   <= $signed({4'd0, sq_res[15:0], 14'd0});
          cy   <= $signed({{4{a_ay[15]}}, a_ay, 14'd0});
          cz   <= 25'sd0;
          ccnt <= 5'd0;
          a_st <= a_zero ? A_DONE : A_CO;
        end
        A_CO: begin
          if (!cy[33]) begin
            cx <= cx + dx;
            cy <= cy - dy;
            cz <= cz + ang;
          end else begin
            cx <= cx - dx;
            cy <= cy + dy;
            cz <= cz - ang;
          end
          ccnt <= ccnt + 5'd1;
          if (ccnt == 5'(CORDIC_RUN - 1)) a_st <= A_DONE;
        end
        A_DONE: ;
        default: a_st <= A_DONE;
      endcase

      unique case (g_st)
        G_MUL0: begin
          g_prod <= 72'(g_mag) * 72'(g_dt[15:0]);
          g_st   <= G_MUL1;
        end
        G_MUL1: begin
          g_prod <= g_prod + ((72'(g_mag) * 72'(g_dt[31:16])) << 16);
          g_st   <= G_CAP;
        end
        G_CAP: begin
          // Increments this large saturate the result anyway.
          g_d   <= (g_shift >= DIV_CAP) ? DIV_W'(DIV_CAP - 61'd1) : g_shift[DIV_W-1:0];
          g_acc <= '0;
          g_cnt <= 2'd0;
          g_st  <= G_DIV;
        end
        G_DIV: begin
          g_acc <= g_acc + pm_s;
          g_cnt <= g_cnt + 2'd1;
          if (g_cnt == 2'd3) g_st <= G_DONE;
        end
        G_DONE: ;
        default: g_st <= G_DONE;
      endcase
    end
  end

endmodule

FILE: tb/sv/tb_tilt_complementary_filter.sv
module tb_tilt_complementary_filter;
  timeunit 1ns;
  timeprecision 1ps;
  import tlp_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_ALPHA;
  logic [23:0] cfg_wdata = '0;

  tilt_complementary_filter dut (.*);

  always #10 clk = ~clk;

  typedef struct packed {
    logic signed [26:0] filt;
    logic signed [23:0] acc;
  } angles_t;

  typedef struct {
    logic signed [15:0] ax, ay, az, rate;
    logic [31:0] ts;
    bit          known;
    angles_t     want;
  } sample_t;

  // Predictor state and gain copies.
  logic [16:0]        alpha_q;
  logic [23:0]        gyro_q;
  logic signed [63:0] angle_q;
  logic [31:0]        time_q;

  angles_t  pending[$];
  int       errors = 0;
  int       words_out = 0;
  int       cycles = 0;
  int       sent = 0;
  bit       drain = 0;

  function automatic logic [31:0] isqrt(input logic [31:0] n);
    logic [31:0] r, b;
    r = 0;
    b = 32'h4000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [23:0] tilt_of(input logic signed [15:0] ax, ay, az);
    logic signed [63:0] x, y, z, dx, dy;
    logic [31:0] m2;
    if (ax == 0 && ay == 0 && az == 0) return '0;
    m2 = 32'(int'(ax) * int'(ax) + int'(az) * int'(az));
    x = 64'(isqrt(m2)) * 16384;
    y = 64'(ay) * 16384;
    z = 0;
    for (int i = 0; i < CORDIC_RUN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += 64'(atan_q16(5'(i)));
      end else begin
        x -= dx; y += dy; z -= 64'(atan_q16(5'(i)));
      end
    end
    if (z > 5898240) z = 5898240;
    if (z < -5898240) z = -5898240;
    return 24'(z);
  endfunction

  function automatic angles_t filter_step(input sample_t s);
    angles_t r;
    logic [31:0] dt;
    logic [127:0] mag, res;
    logic signed [127:0] sum, tot, a;
    dt = s.ts - time_q;
    if (dt == 0) dt = 1;
    time_q = s.ts;
    r.acc = tilt_of(s.ax, s.ay, s.az);
    mag = 128'(s.rate < 0 ? -32'(s.rate) : 32'(s.rate)) * 128'(gyro_q);
    res = (mag * 128'(dt)) / 256000;
    sum = 128'(angle_q) + (s.rate < 0 ? -$signed(res) : $signed(res));
    if (sum > (128'sd1 <<< 44)) sum = 128'sd1 <<< 44;
    if (sum < -(128'sd1 <<< 44)) sum = -(128'sd1 <<< 44);
    a = (alpha_q > ALPHA_ONE) ? 128'sd65536 : 128'(alpha_q);
    tot = (a * sum + (128'sd65536 - a) * 128'(r.acc) + 32768) >>> 16;
    if (tot > 67108863) tot = 67108863;
    if (tot < -67108864) tot = -67108864;
    r.filt = 27'(tot);
    angle_q = 64'(tot);
    return r;
  endfunction

  // Receiver with random stalls; checks every word against the oldest entry.
  initial begin
    int gap;
    forever begin
      gap = drain ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14));
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (m_tvalid !== 1'b1) @(posedge clk);
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, m_tdata);
        errors++;
      end else begin
        angles_t e;
        e = pending.pop_front();
        if (m_tdata[26:0] !== e.filt) begin
          $display("%0t: filtered_angle expected %0d actual %0d", $time, e.filt,
                   $signed(m_tdata[26:0]));
          errors++;
        end
        if (m_tdata[50:27] !== e.acc) begin
          $display("%0t: accel_angle expected %0d actual %0d", $time, e.acc,
                   $signed(m_tdata[50:27]));
          errors++;
        end
        if (m_tdata[55:51] !== '0) begin
          $display("%0t: pad expected 0 actual %h", $time, m_tdata[55:51]);
          errors++;
        end
      end
      words_out++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tilt_complementary_filter verification failed");
      $finish;
    end
  end

  // The word stays valid after its handshake until the next word, an idle
  // gap or a settle replaces or drops it at the following falling edge.
  task automatic send_word(input sample_t s, input bit idle);
    angles_t p;
    int gap;
    gap = idle ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    p = filter_step(s);
    if (s.known && p !== s.want) begin
      $display("%0t: directed row expected %0d/%0d predicted %0d/%0d", $time,
               s.want.filt, s.want.acc, p.filt, p.acc);
      errors++;
    end
    s_tdata <= {s.ts, s.rate, s.az, s.ay, s.ax};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    pending.push_back(p);
    sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [23:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    if (idx == CFG_ALPHA) alpha_q = v[16:0];
    else gyro_q = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic sample_t row(input int ax, ay, az, rate, input logic [31:0] ts,
                                  input bit known = 0, input int f = 0, input int a = 0);
    sample_t s;
    s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az); s.rate = 16'(rate); s.ts = ts;
    s.known = known; s.want.filt = 27'(f); s.want.acc = 24'(a);
    return s;
  endfunction

  function automatic logic signed [15:0] rnd16();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    sample_t tbl[$];
    sample_t s;
    logic [31:0] t;
    alpha_q = ALPHA_RESET;
    gyro_q = GYRO_RESET;
    angle_q = 0;
    time_q = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Zero accel and zero rate right after reset give zero, and a zero time
    // step is taken as one millisecond.
    tbl.push_back(row(0, 0, 0, 0, 0, 1, 0, 0));
    tbl.push_back(row(0, 0, 0, 0, 0, 1, 0, 0));
    tbl.push_back(row(0, 1000, 0, 0, 5));
    tbl.push_back(row(0, -1000, 0, 0, 6));
    tbl.push_back(row(-32768, -32768, -32768, -32768, 32'hffff_ffff));
    tbl.push_back(row(32767, 32767, 32767, 32767, 32'h0000_0001));
    tbl.push_back(row(1000, 0, 0, 32767, 32'h8000_0000));
    tbl.push_back(row(0, 0, -32768, -32768, 32'h7fff_ffff));
    tbl.push_back(row(16384, 16384, 0, 100, 32'h7fff_ffff));
    tbl.push_back(row(0, 1, 0, -1, 32'h7fff_fff0));
    foreach (tbl[i]) send_word(tbl[i], 1);

    // Alpha at and above one, alpha zero, and gains at their extremes.
    write_reg(CFG_ALPHA, 24'd65536);
    send_word(row(0, 0, 100, 32767, 32'h0000_1000), 1);
    write_reg(CFG_ALPHA, 24'h01ffff);
    write_reg(CFG_GYRO, 24'hffffff);
    send_word(row(0, 0, 0, 32767, 32'h8000_1000), 1);
    send_word(row(0, 0, 0, -32768, 32'h0000_1000), 1);
    write_reg(CFG_ALPHA, 24'd0);
    send_word(row(0, 0, 0, 0, 32'h0000_1001, 1, 0, 0), 1);
    send_word(row(0, 5, 0, 32767, 32'h0000_2001), 1);
    write_reg(CFG_GYRO, 24'd0);
    write_reg(CFG_ALPHA, 24'd32768);
    send_word(row(3, -4, 5, -32768, 32'h0000_3001), 1);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(CFG_ALPHA, 24'(ALPHA_RESET)); write_reg(CFG_GYRO, GYRO_RESET); end
        1: begin write_reg(CFG_ALPHA, 24'($urandom_range(0, 131071)));
                 write_reg(CFG_GYRO, 24'($urandom)); end
        2: begin write_reg(CFG_ALPHA, 24'd65536); write_reg(CFG_GYRO, 24'hffffff); end
        3: begin write_reg(CFG_ALPHA, 24'd0); write_reg(CFG_GYRO, 24'd1); end
        default: begin write_reg(CFG_ALPHA, 24'($urandom_range(60000, 65536)));
                       write_reg(CFG_GYRO, 24'($urandom_range(0, 1000000))); end
      endcase
      t = $urandom;
      for (int k = 0; k < 86; k++) begin
        // Mostly steps of 1 to 40 ms, with repeats and wild jumps mixed in.
        case ($urandom_range(0, 9))
          0: t = $urandom;
          1: ;
          default: t = t + $urandom_range(1, 40);
        endcase
        s = row(rnd16(), rnd16(), rnd16(), rnd16(), t);
        if ($urandom_range(0, 15) == 0) begin
          s.ax = 0; s.az = 0;
        end
        if (k == 40) settle();
        send_word(s, $urandom_range(0, 3) != 0);
      end
    end

    drain = 1;
    settle();
    $display("Sent %0d words through five gain settings, received %0d.", sent, words_out);
    $display("Covered zero and wrapped time steps, zero accel, and alpha above one.");
    if (errors == 0) begin
      $display("tilt_complementary_filter verification clean");
    end else begin
      $display("tilt_complementary_filter verification failed");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+src
src/tlp_pkg.sv
src/tlp_front.sv
src/tlp_fifo.sv
src/tlp_back.sv
src/tilt_complementary_filter.sv
tb/sv/tb_tilt_complementary_filter.sv
